>>> design/pvf_pkg.sv
// Shared constants, item and divider types for the point visibility block.
package pvf_pkg;

	localparam int MAX_FACES = 16;
	localparam int FIDX_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
	localparam int CNT_W = $clog2(MAX_FACES + 1);
	localparam int CADDR_W = FIDX_W + 2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int DEN_W = 50;
	localparam int REM_W = DEN_W + 1;

	localparam int PADDR_W = 3;
	localparam logic REG_FACE_COUNT = 1'b0;

	// 100 * L1 < 65536 holds exactly for L1 below this bound.
	localparam logic [34:0] NEAR_L1_LIMIT = 35'd656;
	localparam logic [64:0] DEPTH_MARGIN = 65'd42949673;

	localparam logic [1:0] KIND_CORNER = 2'd0;
	localparam logic [1:0] KIND_PLANE = 2'd1;
	localparam logic [1:0] KIND_TEST = 2'd2;

	typedef enum logic [1:0] {
		OP_CORNER = 2'd0,
		OP_PLANE = 2'd1,
		OP_TEST = 2'd2
	} op_t;

	typedef struct packed {
		op_t op;
		logic [4:0] slot;
		logic [4:0] other;
		logic [1:0] corner;
		logic signed [12:0] cx;
		logic signed [12:0] cy;
		logic signed [20:0] ix;
		logic signed [20:0] iy;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] vw;
		logic off;
	} item_t;

	typedef struct packed {
		logic start;
		logic [2:0][63:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [2:0][31:0] cut;
	} div_rsp_t;

endpackage

>>> design/pvf_front.sv
// Front end: accepts items, rounds corners, flags off-image tests, drops ignored items.
module pvf_front (
	input  logic start,
	input  logic busy,
	input  logic [1:0] kind,
	input  logic [4:0] face_slot,
	input  logic [4:0] other_face,
	input  logic [1:0] corner,
	input  logic signed [20:0] img_x,
	input  logic signed [20:0] img_y,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] vec_w,
	output logic push,
	output pvf_pkg::item_t item
);
	import pvf_pkg::*;

	logic accept;
	logic slot_ok;

	// Round half up to whole pixels, truncating toward zero, clamped to 13 bits.
	function automatic logic signed [12:0] round_corner(input logic signed [20:0] v);
		logic signed [21:0] s;
		logic signed [21:0] q;
		s = 22'(v) + 22'sd128;
		q = (s < 22'sd0) ? ((s + 22'sd255) >>> 8) : (s >>> 8);
		if (q > 22'sd4095) begin
			return 13'sd4095;
		end
		return 13'(q);
	endfunction

	assign accept = start && !busy;
	assign slot_ok = 32'(face_slot) < MAX_FACES;

	always_comb begin
		push = 1'b0;
		item.op = OP_TEST;
		unique case (kind)
			KIND_CORNER: begin
				item.op = OP_CORNER;
				push = accept && slot_ok;
			end
			KIND_PLANE: begin
				item.op = OP_PLANE;
				push = accept && slot_ok;
			end
			KIND_TEST: begin
				item.op = OP_TEST;
				push = accept;
			end
			default: push = 1'b0;
		endcase
		item.slot = face_slot;
		item.other = other_face;
		item.corner = corner;
		item.cx = round_corner(img_x);
		item.cy = round_corner(img_y);
		item.ix = img_x;
		item.iy = img_y;
		item.vx = vec_x;
		item.vy = vec_y;
		item.vz = vec_z;
		item.vw = vec_w;
		item.off = (img_x < 21'sd256) || (img_y < 21'sd256);
	end

endmodule

>>> design/pvf_queue.sv
// Short word queue between the front end and the face walker.
module pvf_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pvf_pkg::item_t item_in,
	input  logic pop,
	output pvf_pkg::item_t head,
	output logic full,
	output logic empty
);
	import pvf_pkg::*;

	item_t slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full = count_q == QCNT_W'(QDEPTH);
	assign empty = count_q == '0;
	assign head = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("word pushed into a full queue");

endmodule

>>> design/pvf_div.sv
// Three-lane restoring divider for the ray and plane cut, one quotient bit per cycle.
module pvf_div (
	input  logic clk,
	input  logic arst_n,
	input  pvf_pkg::div_req_t req,
	output pvf_pkg::div_rsp_t rsp
);
	import pvf_pkg::*;

	logic run_q;
	logic done_q;
	logic [4:0] step_q;
	logic [DEN_W-1:0] dmag_q;
	logic [2:0][REM_W-1:0] rem_q;
	logic [2:0][31:0] nlo_q;
	logic [2:0][31:0] quo_q;
	logic [2:0] neg_q;
	logic [2:0] ovf_q;

	logic signed [DEN_W-1:0] den_s;
	logic [DEN_W-1:0] dmag;
	logic [2:0][63:0] nmag;
	logic [2:0][REM_W-1:0] trial;
	logic [2:0][REM_W-1:0] rem_n;
	logic [2:0] qbit;
	logic [2:0] ovf;

	assign den_s = $signed(req.den);
	assign dmag = den_s[DEN_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nmag[i] = req.num[i][63] ? (~req.num[i] + 64'd1) : req.num[i];
			// A quotient of 2^32 or more saturates whatever its sign.
			ovf[i] = DEN_W'(nmag[i][63:32]) >= dmag;
			trial[i] = {rem_q[i][REM_W-2:0], nlo_q[i][31]};
			qbit[i] = trial[i] >= {1'b0, dmag_q};
			rem_n[i] = qbit[i] ? (trial[i] - {1'b0, dmag_q}) : trial[i];
			if (ovf_q[i]) begin
				rsp.cut[i] = neg_q[i] ? 32'h8000_0000 : 32'h7fff_ffff;
			end else if (!neg_q[i]) begin
				rsp.cut[i] = quo_q[i][31] ? 32'h7fff_ffff : quo_q[i];
			end else begin
				rsp.cut[i] = (quo_q[i] > 32'h8000_0000) ? 32'h8000_0000 : (~quo_q[i] + 32'd1);
			end
		end
		rsp.done = done_q;
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dmag_q <= dmag;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= REM_W'(nmag[i][63:32]);
				nlo_q[i] <= nmag[i][31:0];
				quo_q[i] <= '0;
				neg_q[i] <= req.num[i][63] ^ req.den[DEN_W-1];
				ovf_q[i] <= ovf[i];
			end
		end else if (run_q) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= rem_n[i];
				nlo_q[i] <= {nlo_q[i][30:0], 1'b0};
				quo_q[i] <= {quo_q[i][30:0], qbit[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> design/pvf_back.sv
// Back end: face tables, quad coverage test, plane cut and depth decision per test word.
module pvf_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  pvf_pkg::item_t q_head,
	output logic q_pop,
	input  logic [4:0] face_count,
	output logic done,
	output logic visible
);
	import pvf_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_FACE = 10'b00_0000_0010,
		S_READ = 10'b00_0000_0100,
		S_EDGE_A = 10'b00_0000_1000,
		S_EDGE_B = 10'b00_0001_0000,
		S_EDGE_C = 10'b00_0010_0000,
		S_MUL = 10'b00_0100_0000,
		S_DIV = 10'b00_1000_0000,
		S_SQ = 10'b01_0000_0000,
		S_DECIDE = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic done_q;
	logic vis_q;
	logic fin;
	logic fin_vis;
	logic adv_face;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] n_q;
	logic [2:0] rd_k_q;
	logic [1:0] ek_q;
	logic par_q;
	logic [3:0] step_q;

	logic [25:0] corner_mem [MAX_FACES*4];
	logic [127:0] plane_mem [MAX_FACES];
	logic [25:0] corner_rd_q;
	logic [127:0] plane_rd_q;
	logic corner_re;
	logic plane_re;

	item_t item_q;
	logic signed [12:0] vx_q [4];
	logic signed [12:0] vy_q [4];
	logic signed [63:0] prod_q;
	logic signed [63:0] m1_q;
	logic signed [DEN_W-1:0] den_q;
	logic [2:0][63:0] num_q;
	logic [2:0][31:0] cut_q;
	logic [63:0] me_q;
	logic [63:0] pe_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [24:0] x0, y0, x1, y1, px, py;
	logic signed [24:0] dx, dy, dx1, dy1, dx2, dy2;
	logic signed [63:0] cr;
	logic vhit, onedge, between, no_cross, num_pos, par_n;
	logic own_face;
	logic signed [63:0] tr_adj;
	logic signed [DEN_W-1:0] den_term;
	logic [34:0] l1;
	logic signed [32:0] diff [3];
	logic depth_hit;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign done = done_q;
	assign visible = vis_q;

	// Face tables.
	assign corner_re = (state_q == S_READ) && (rd_k_q < 3'd4);
	assign plane_re = (state_q == S_READ) && (rd_k_q == 3'd0);

	always_ff @(posedge clk) begin
		if (q_pop && (q_head.op == OP_CORNER)) begin
			corner_mem[{FIDX_W'(q_head.slot), q_head.corner}] <= {q_head.cx, q_head.cy};
		end
		if (corner_re) begin
			corner_rd_q <= corner_mem[{j_q[FIDX_W-1:0], rd_k_q[1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_head.op == OP_PLANE)) begin
			plane_mem[FIDX_W'(q_head.slot)] <= {q_head.vx, q_head.vy, q_head.vz, q_head.vw};
		end
		if (plane_re) begin
			plane_rd_q <= plane_mem[j_q[FIDX_W-1:0]];
		end
	end

	// The current edge always runs from vertex tap 3 to vertex tap 0.
	always_comb begin
		x0 = 25'(signed'({vx_q[3], 8'h00}));
		y0 = 25'(signed'({vy_q[3], 8'h00}));
		x1 = 25'(signed'({vx_q[0], 8'h00}));
		y1 = 25'(signed'({vy_q[0], 8'h00}));
		px = 25'(item_q.ix) + 25'sd128;
		py = 25'(item_q.iy) + 25'sd128;
		dx = x1 - x0;
		dy = y1 - y0;
		dx1 = px - x0;
		dy1 = py - y0;
		dx2 = px - x1;
		dy2 = py - y1;
		cr = m1_q - prod_q;
		vhit = ((dx1 == 25'sd0) && (dy1 == 25'sd0)) || ((dx2 == 25'sd0) && (dy2 == 25'sd0));
		// On a collinear point, lying strictly between the ends is a coordinate range check.
		if (dx != 25'sd0) begin
			between = ((x0 < px) && (px < x1)) || ((x1 < px) && (px < x0));
		end else begin
			between = ((y0 < py) && (py < y1)) || ((y1 < py) && (py < y0));
		end
		onedge = (cr == 64'sd0) && between;
		no_cross = ((y0 <= py) && (y1 <= py)) || ((y0 > py) && (y1 > py)) ||
			((x0 < px) && (x1 < px));
		num_pos = (dy < 25'sd0) ? (cr < 64'sd0) : (cr > 64'sd0);
		par_n = par_q ^ (!no_cross && num_pos);
	end

	assign own_face = (32'(j_q) == 32'(item_q.slot)) || (32'(j_q) == 32'(item_q.other));

	// Shared multiplier operand select.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		priority if (state_q == S_EDGE_A) begin
			mul_a = 32'(dy1);
			mul_b = 32'(dx);
		end else if (state_q == S_EDGE_B) begin
			mul_a = 32'(dx1);
			mul_b = 32'(dy);
		end else if (state_q == S_MUL) begin
			unique case (step_q)
				4'd0: begin mul_a = $signed(plane_rd_q[127:96]); mul_b = item_q.vx; end
				4'd1: begin mul_a = $signed(plane_rd_q[95:64]); mul_b = item_q.vy; end
				4'd2: begin mul_a = $signed(plane_rd_q[63:32]); mul_b = item_q.vz; end
				4'd3: begin mul_a = $signed(plane_rd_q[31:0]); mul_b = item_q.vx; end
				4'd4: begin mul_a = $signed(plane_rd_q[31:0]); mul_b = item_q.vy; end
				4'd5: begin mul_a = $signed(plane_rd_q[31:0]); mul_b = item_q.vz; end
				4'd6: begin mul_a = item_q.vx; mul_b = item_q.vx; end
				4'd7: begin mul_a = item_q.vy; mul_b = item_q.vy; end
				4'd8: begin mul_a = item_q.vz; mul_b = item_q.vz; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == S_SQ) begin
			unique case (step_q)
				4'd0: begin mul_a = $signed(cut_q[0]); mul_b = $signed(cut_q[0]); end
				4'd1: begin mul_a = $signed(cut_q[1]); mul_b = $signed(cut_q[1]); end
				4'd2: begin mul_a = $signed(cut_q[2]); mul_b = $signed(cut_q[2]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	// Plane term divided by 65536 with truncation toward zero.
	assign tr_adj = prod_q + ((prod_q < 64'sd0) ? 64'sd65535 : 64'sd0);
	assign den_term = DEN_W'(tr_adj >>> 16);

	always_comb begin
		diff[0] = 33'(item_q.vx) - 33'($signed(cut_q[0]));
		diff[1] = 33'(item_q.vy) - 33'($signed(cut_q[1]));
		diff[2] = 33'(item_q.vz) - 33'($signed(cut_q[2]));
		l1 = '0;
		for (int i = 0; i < 3; i++) begin
			l1 = l1 + 35'(diff[i][32] ? -diff[i] : diff[i]);
		end
	end

	assign depth_hit = {1'b0, me_q} >= ({1'b0, pe_q} + DEPTH_MARGIN);

	assign div_req.start = (state_q == S_MUL) && (step_q == 4'd9) && (den_q != '0);
	assign div_req.num = num_q;
	assign div_req.den = den_q;

	pvf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	always_comb begin
		state_d = state_q;
		fin = 1'b0;
		fin_vis = 1'b1;
		adv_face = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_pop && (q_head.op == OP_TEST)) begin
					if (q_head.off) begin
						fin = 1'b1;
						fin_vis = 1'b0;
					end else begin
						state_d = S_FACE;
					end
				end
			end
			S_FACE: begin
				if (j_q >= n_q) begin
					fin = 1'b1;
					state_d = S_IDLE;
				end else if (own_face) begin
					adv_face = 1'b1;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: if (rd_k_q == 3'd4) state_d = S_EDGE_A;
			S_EDGE_A: state_d = S_EDGE_B;
			S_EDGE_B: state_d = S_EDGE_C;
			S_EDGE_C: begin
				if (vhit || onedge) begin
					adv_face = 1'b1;
				end else if (ek_q == 2'd3) begin
					if (par_n) begin
						state_d = S_MUL;
					end else begin
						adv_face = 1'b1;
					end
				end else begin
					state_d = S_EDGE_A;
				end
			end
			S_MUL: begin
				if (step_q == 4'd9) begin
					state_d = (den_q == '0) ? S_SQ : S_DIV;
				end
			end
			S_DIV: if (div_rsp.done) state_d = S_SQ;
			S_SQ: if (step_q == 4'd3) state_d = S_DECIDE;
			S_DECIDE: begin
				if (l1 < NEAR_L1_LIMIT) begin
					adv_face = 1'b1;
				end else if (depth_hit) begin
					fin = 1'b1;
					fin_vis = 1'b0;
					state_d = S_IDLE;
				end else begin
					adv_face = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (adv_face) begin
			state_d = S_FACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			j_q <= '0;
			n_q <= '0;
			rd_k_q <= '0;
			ek_q <= '0;
			par_q <= 1'b0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= fin;
			if (state_q == S_IDLE) begin
				j_q <= '0;
			end else if (adv_face) begin
				j_q <= j_q + 1'b1;
			end
			if (q_pop) begin
				n_q <= (32'(face_count) > MAX_FACES) ? CNT_W'(MAX_FACES) : CNT_W'(face_count);
			end
			rd_k_q <= (state_q == S_READ) ? (rd_k_q + 3'd1) : 3'd0;
			if (state_q == S_READ) begin
				ek_q <= '0;
				par_q <= 1'b0;
			end else if (state_q == S_EDGE_C) begin
				ek_q <= ek_q + 2'd1;
				par_q <= par_n;
			end
			if (((state_q == S_MUL) || (state_q == S_SQ)) && (state_d == state_q)) begin
				step_q <= step_q + 4'd1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (fin) begin
			vis_q <= fin_vis;
		end
		if (q_pop) begin
			item_q <= q_head;
		end
		if ((state_q == S_READ) && (rd_k_q != 3'd0)) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= vx_q[i+1];
				vy_q[i] <= vy_q[i+1];
			end
			vx_q[3] <= $signed(corner_rd_q[25:13]);
			vy_q[3] <= $signed(corner_rd_q[12:0]);
		end
		if (state_q == S_EDGE_B) begin
			m1_q <= prod_q;
		end
		if (state_q == S_EDGE_C) begin
			for (int i = 0; i < 4; i++) begin
				vx_q[i] <= vx_q[(i + 1) % 4];
				vy_q[i] <= vy_q[(i + 1) % 4];
			end
			den_q <= '0;
			me_q <= '0;
		end
		if (state_q == S_MUL) begin
			unique case (step_q)
				4'd1, 4'd2, 4'd3: den_q <= den_q + den_term;
				4'd4: num_q[0] <= 64'(-prod_q);
				4'd5: num_q[1] <= 64'(-prod_q);
				4'd6: num_q[2] <= 64'(-prod_q);
				4'd7, 4'd8: me_q <= me_q + $unsigned(prod_q);
				4'd9: begin
					me_q <= me_q + $unsigned(prod_q);
					pe_q <= '0;
					if (den_q == '0) begin
						cut_q <= '0;
					end
				end
				default: den_q <= den_q;
			endcase
		end
		if ((state_q == S_DIV) && div_rsp.done) begin
			cut_q <= div_rsp.cut;
		end
		if ((state_q == S_SQ) && (step_q != 4'd0)) begin
			pe_q <= pe_q + $unsigned(prod_q);
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (den_q != '0))
		else $error("divider started with a zero plane denominator");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (j_q < n_q))
		else $error("face walk read past the face count");

	a_cover_first: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_MUL) && (step_q == 4'd0)) |-> ($past(state_q) == S_EDGE_C))
		else $error("plane cut entered without a completed quad test");

endmodule

>>> design/point_visibility_against_faces_core.sv
// Point visibility core: words are taken whenever busy is low, and busy rises only when the
// four-word queue is full. Corner and plane loads are written to the face tables as the face
// walker pops them. A test word gives exactly one result, as a one-cycle done strobe with
// visible, which the receiver must take at once. An off-image test resolves without a walk;
// otherwise the walker skips an own face, tests the quad of every other face (five table
// reads, then each edge on the shared multiplier), and for a covering face gets the plane cut
// from the cut divider, unless its denominator is zero, before the depth decision.
module point_visibility_against_faces_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] kind,
	input  logic [4:0] face_slot,
	input  logic [4:0] other_face,
	input  logic [1:0] corner,
	input  logic signed [20:0] img_x,
	input  logic signed [20:0] img_y,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] vec_w,
	output logic done,
	output logic visible,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pvf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pvf_pkg::*;

	logic [4:0] face_count_q;
	logic push;
	logic pop;
	logic full;
	logic empty;
	item_t item;
	item_t head;

	assign pready = 1'b1;
	assign busy = full;
	assign prdata = (paddr[2] == REG_FACE_COUNT) ? {27'd0, face_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_count_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FACE_COUNT)) begin
			face_count_q <= pwdata[4:0];
		end
	end

	pvf_front u_front (
		.start(start),
		.busy(full),
		.kind(kind),
		.face_slot(face_slot),
		.other_face(other_face),
		.corner(corner),
		.img_x(img_x),
		.img_y(img_y),
		.vec_x(vec_x),
		.vec_y(vec_y),
		.vec_z(vec_z),
		.vec_w(vec_w),
		.push(push),
		.item(item)
	);

	pvf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item_in(item),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	pvf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(empty),
		.q_head(head),
		.q_pop(pop),
		.face_count(face_count_q),
		.done(done),
		.visible(visible)
	);

endmodule

>>> dv/pvf_checker.sv
// Scoreboard for the point visibility core: models the face tables and checks each visible bit.
module pvf_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic [1:0] kind,
	input  logic [4:0] face_slot,
	input  logic [4:0] other_face,
	input  logic [1:0] corner,
	input  logic signed [20:0] img_x,
	input  logic signed [20:0] img_y,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] vec_w,
	input  logic done,
	input  logic visible,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pvf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int mismatches,
	output int pending,
	output int tests_seen,
	output int hidden_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import pvf_pkg::*;

	longint corner_xs[MAX_FACES*4];
	longint corner_ys[MAX_FACES*4];
	longint plane_coef[MAX_FACES*4];
	logic [4:0] faces_walked;
	bit visible_due[$];

	function automatic longint round_pixel(longint v);
		longint q;
		q = (v + 128) / 256;
		if (q > 4095) q = 4095;
		if (q < -4096) q = -4096;
		return q;
	endfunction

	// Strict even-odd test in 1/256 pixel units; edges and vertices count as outside.
	function automatic bit quad_covers(int f, longint px, longint py);
		longint vx[4], vy[4];
		longint x0, y0, x1, y1, dx, dy, dx1, dy1, dx2, dy2, cr, num;
		int k, p, cnt;
		cnt = 0;
		for (k = 0; k < 4; k++) begin
			vx[k] = corner_xs[f*4+k] * 256;
			vy[k] = corner_ys[f*4+k] * 256;
		end
		for (k = 0; k < 4; k++) begin
			p = (k + 3) % 4;
			x0 = vx[p]; y0 = vy[p]; x1 = vx[k]; y1 = vy[k];
			dx = x1 - x0; dy = y1 - y0;
			dx1 = px - x0; dy1 = py - y0;
			dx2 = px - x1; dy2 = py - y1;
			cr = dy1 * dx - dx1 * dy;
			if (dx1 == 0 && dy1 == 0) return 0;
			if (dx2 == 0 && dy2 == 0) return 0;
			if (cr == 0 && dx1 * dx + dy1 * dy > 0 && dx2 * dx + dy2 * dy < 0) return 0;
			if ((y0 <= py && y1 <= py) || (y0 > py && y1 > py) || (x0 < px && x1 < px))
				continue;
			num = (dy < 0) ? -cr : cr;
			if (num > 0) cnt++;
		end
		return cnt[0];
	endfunction

	function automatic bit plane_hides(int f, longint pt[3]);
		longint den, l1, d, q;
		longint cut[3];
		logic [63:0] me, pe;
		int i;
		den = 0; l1 = 0; me = 0; pe = 0;
		d = plane_coef[f*4+3];
		for (i = 0; i < 3; i++) begin
			cut[i] = 0;
			den += (plane_coef[f*4+i] * pt[i]) / 65536;
		end
		// A zero denominator means the ray runs parallel, and the cut stays at the eye.
		if (den != 0)
			for (i = 0; i < 3; i++) begin
				q = -(d * pt[i]) / den;
				if (q > 64'sd2147483647) q = 64'sd2147483647;
				if (q < -64'sd2147483648) q = -64'sd2147483648;
				cut[i] = q;
			end
		for (i = 0; i < 3; i++)
			l1 += (pt[i] > cut[i]) ? pt[i] - cut[i] : cut[i] - pt[i];
		if (l1 * 100 < 65536) return 0;
		for (i = 0; i < 3; i++) begin
			me += 64'(pt[i] * pt[i]);
			pe += 64'(cut[i] * cut[i]);
		end
		return me > pe && me - pe >= 64'd42949673;
	endfunction

	function automatic bit predict_visible(longint ix, longint iy, longint pt[3],
			int own_a, int own_b);
		int n, j;
		if (ix < 256 || iy < 256) return 0;
		n = (faces_walked > MAX_FACES) ? MAX_FACES : faces_walked;
		for (j = 0; j < n; j++) begin
			if (j == own_a || j == own_b) continue;
			if (!quad_covers(j, ix + 128, iy + 128)) continue;
			if (plane_hides(j, pt)) return 0;
		end
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint pt[3];
		bit want;
		int s;
		if (!arst_n) begin
			faces_walked <= '0;
			mismatches <= 0;
			tests_seen <= 0;
			hidden_seen <= 0;
			visible_due.delete();
			pending <= 0;
		end else begin
			s = face_slot;
			if (psel && penable && pwrite && pready && paddr[2] == REG_FACE_COUNT)
				faces_walked <= pwdata[4:0];
			if (start && !busy) begin
				case (kind)
					KIND_CORNER: begin
						if (s < MAX_FACES) begin
							corner_xs[s*4+corner] = round_pixel(img_x);
							corner_ys[s*4+corner] = round_pixel(img_y);
						end
					end
					KIND_PLANE: begin
						if (s < MAX_FACES) begin
							plane_coef[s*4] = vec_x;
							plane_coef[s*4+1] = vec_y;
							plane_coef[s*4+2] = vec_z;
							plane_coef[s*4+3] = vec_w;
						end
					end
					KIND_TEST: begin
						pt[0] = vec_x; pt[1] = vec_y; pt[2] = vec_z;
						visible_due.push_back(predict_visible(img_x, img_y, pt, s,
							other_face));
						tests_seen <= tests_seen + 1;
					end
					default: ;
				endcase
			end
			if (done) begin
				if (visible_due.size() == 0) begin
					if (mismatches < 10) $display("%t: unexpected result word", $realtime);
					mismatches <= mismatches + 1;
				end else begin
					want = visible_due.pop_front();
					if (!visible) hidden_seen <= hidden_seen + 1;
					if (visible !== want) begin
						if (mismatches < 10)
							$display("%t: visible mismatch, expected %0b got %0b",
								$realtime, want, visible);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= visible_due.size();
		end
	end

endmodule

>>> dv/point_visibility_against_faces_core_test.sv
// Top of the point visibility testbench: stimulus, register writes and the verdict.
module point_visibility_against_faces_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pvf_pkg::*;

	logic clk, arst_n, start, busy, done, visible;
	logic [1:0] kind, corner;
	logic [4:0] face_slot, other_face;
	logic signed [20:0] img_x, img_y;
	logic signed [31:0] vec_x, vec_y, vec_z, vec_w;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	int mismatches, pending, tests_seen, hidden_seen;
	int idle_pct, quiet_cycles;

	point_visibility_against_faces_core uut (.*);
	pvf_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Any accepted word, result or register access counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || done || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 40000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_word(logic [1:0] k, logic [4:0] s, logic [4:0] o, logic [1:0] c,
			logic [20:0] ix, logic [20:0] iy, logic [31:0] vx, logic [31:0] vy,
			logic [31:0] vz, logic [31:0] vw);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k; face_slot <= s; other_face <= o; corner <= c;
		img_x <= ix; img_y <= iy;
		vec_x <= vx; vec_y <= vy; vec_z <= vz; vec_w <= vw;
		forever begin
			@(negedge clk);
			if (!busy) break;
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	task automatic write_reg(logic [PADDR_W-1:0] a, logic [31:0] d);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [20:0] to_img(int px);
		return 21'(px * 256 + $urandom_range(0, 255) - 128);
	endfunction

	task automatic load_face(logic [4:0] f);
		int x0, y0, x1, y1, depth;
		x0 = $urandom_range(1, 300); x1 = x0 + $urandom_range(2, 120);
		y0 = $urandom_range(1, 300); y1 = y0 + $urandom_range(2, 120);
		depth = $urandom_range(1, 60);
		send_word(KIND_CORNER, f, 5'($urandom), 2'd0, to_img(x0), to_img(y0), $urandom,
			$urandom, $urandom, $urandom);
		send_word(KIND_CORNER, f, 5'($urandom), 2'd1, to_img(x1), to_img(y0 + $urandom_range(0, 3)),
			$urandom, $urandom, $urandom, $urandom);
		send_word(KIND_CORNER, f, 5'($urandom), 2'd2, to_img(x1), to_img(y1), $urandom,
			$urandom, $urandom, $urandom);
		send_word(KIND_CORNER, f, 5'($urandom), 2'd3, to_img(x0 + $urandom_range(0, 3)),
			to_img(y1), $urandom, $urandom, $urandom, $urandom);
		case ($urandom_range(19))
			0, 1: send_word(KIND_PLANE, f, 0, 0, 21'($urandom), 21'($urandom), $urandom,
				$urandom, $urandom, $urandom);
			2: send_word(KIND_PLANE, f, 0, 0, 0, 0, 0, 0, 0, 32'(-depth * 65536));
			default: send_word(KIND_PLANE, f, 0, 0, 0, 0, 32'($urandom_range(0, 16383) - 8192),
				32'($urandom_range(0, 16383) - 8192), 32'd65536, 32'(-depth * 65536));
		endcase
	endtask

	task automatic random_test();
		logic [20:0] ix, iy;
		logic [31:0] px, py, pz;
		if ($urandom_range(9) == 0) begin
			ix = 21'($urandom); iy = 21'($urandom);
		end else begin
			ix = to_img($urandom_range(0, 440)); iy = to_img($urandom_range(0, 440));
		end
		if ($urandom_range(9) == 0) begin
			px = $urandom; py = $urandom; pz = $urandom;
		end else begin
			px = 32'($urandom_range(0, 2621440) - 1310720);
			py = 32'($urandom_range(0, 2621440) - 1310720);
			pz = 32'($urandom_range(65536, 80 * 65536));
		end
		send_word(KIND_TEST, 5'($urandom), 5'($urandom), 2'($urandom), ix, iy, px, py, pz,
			$urandom);
	endtask

	initial begin
		logic [4:0] counts[5];
		int ph, n, r;
		arst_n = 1'b0; start = 1'b0; kind = '0; face_slot = '0; other_face = '0;
		corner = '0; img_x = '0; img_y = '0; vec_x = '0; vec_y = '0; vec_z = '0;
		vec_w = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0;
		pwdata = '0; quiet_cycles = 0; idle_pct = 22;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Every table entry gets written before any test can walk it.
		for (int f = 0; f < MAX_FACES; f++) load_face(5'(f));
		// Face 0 spans pixels 10..50 at depth 2, face 1 the same quad at depth 10.
		for (int f = 0; f < 2; f++) begin
			send_word(KIND_CORNER, 5'(f), 0, 2'd0, 21'(10*256), 21'(10*256), 0, 0, 0, 0);
			send_word(KIND_CORNER, 5'(f), 0, 2'd1, 21'(50*256), 21'(10*256), 0, 0, 0, 0);
			send_word(KIND_CORNER, 5'(f), 0, 2'd2, 21'(50*256), 21'(50*256), 0, 0, 0, 0);
			send_word(KIND_CORNER, 5'(f), 0, 2'd3, 21'(10*256), 21'(50*256), 0, 0, 0, 0);
			send_word(KIND_PLANE, 5'(f), 0, 0, 0, 0, 0, 0, 32'd65536,
				32'(-(f * 8 + 2) * 65536));
		end
		settle();
		write_reg(PADDR_W'(4), 32'd3);
		write_reg(PADDR_W'(0), 32'd16);
		settle();
		send_word(KIND_TEST, 5'd31, 5'd31, 0, 21'(255), 21'(30*256), 0, 0, 32'd327680, 0);
		send_word(KIND_TEST, 5'd31, 5'd31, 0, 21'(30*256), 21'(255), 0, 0, 32'd327680, 0);
		send_word(KIND_TEST, 5'd31, 5'd31, 0, 21'h100000, 21'h0FFFFF, 0, 0, 0, 0);
		send_word(KIND_TEST, 5'd31, 5'd31, 0, 21'h0FFFFF, 21'h0FFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
		send_word(KIND_TEST, 5'd20, 5'd20, 0, 21'(30*256), 21'(30*256), 0, 0, 32'd327680, 0);
		send_word(KIND_TEST, 5'd0, 5'd20, 0, 21'(30*256), 21'(30*256), 0, 0, 32'd327680, 0);
		send_word(KIND_TEST, 5'd0, 5'd1, 0, 21'(30*256), 21'(30*256), 0, 0, 32'd327680, 0);
		send_word(KIND_TEST, 5'd1, 5'd31, 0, 21'(30*256), 21'(30*256), 0, 0, 32'd131072, 0);
		// Shifted point exactly on a vertex, then on an edge.
		send_word(KIND_TEST, 5'd31, 5'd31, 0, 21'(10*256-128), 21'(10*256-128), 0, 0,
			32'd327680, 0);
		send_word(KIND_TEST, 5'd31, 5'd31, 0, 21'(30*256-128), 21'(10*256-128), 0, 0,
			32'd327680, 0);
		send_word(2'd3, 5'd0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_word(KIND_PLANE, 5'd31, 0, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0);
		send_word(KIND_CORNER, 5'd16, 0, 2'd3, 21'h100000, 21'h0FFFFF, 0, 0, 0, 0);
		send_word(KIND_TEST, 5'd31, 5'd31, 0, 21'(30*256), 21'(30*256), 32'h80000000,
			32'h80000000, 32'h80000000, 0);
		counts[0] = 5'd16; counts[1] = 5'd0; counts[2] = 5'($urandom_range(1, 15));
		counts[3] = 5'd31; counts[4] = 5'd17;
		for (ph = 0; ph < 5; ph++) begin
			idle_pct = (ph < 2) ? 22 : (ph < 4) ? 64 : 0;
			settle();
			write_reg(PADDR_W'(0), {27'($urandom), counts[ph]});
			n = 0;
			while (n < 160) begin
				r = $urandom_range(99);
				if (r < 70) begin
					random_test();
					n++;
				end else if (r < 82) begin
					load_face(5'($urandom_range(0, MAX_FACES - 1)));
					n += 5;
				end else if (r < 88) begin
					send_word(2'($urandom), 5'($urandom), 5'($urandom), 2'($urandom),
						21'($urandom), 21'($urandom), $urandom, $urandom, $urandom, $urandom);
					n++;
				end else begin
					send_word(KIND_CORNER, 5'($urandom_range(MAX_FACES, 31)), 0, 2'($urandom),
						21'($urandom), 21'($urandom), 0, 0, 0, 0);
					n++;
				end
			end
		end
		settle();
		repeat (50) @(posedge clk);
		$display("Covered %0d test points (%0d hidden) over five face counts and idle mixes.",
			tests_seen, hidden_seen);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
